// File: rtl/fcfl_pkg.sv
// shared types and constants of the fixed-chunk free-list allocator
// no dependencies
package fcfl_pkg;

   localparam int DEFAULT_MAX_CHUNKS = 1024;
   localparam int CMD_W    = 1;
   localparam int INDEX_W  = 10;
   localparam int COUNT_W  = 11;
   localparam int STATUS_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_ALLOC = 2'd0,
      STAT_FREED = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_BAD   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic execute;
   } ctl_type;

endpackage

// File: rtl/fcfl_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module fcfl_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/fcfl_ctrl.sv
// controller: sequences one word through capture and execute, owns the response valid
// depends on fcfl_pkg
module fcfl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fcfl_pkg::ctl_type ctl
);
   import fcfl_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_stall = !((state_ff == ST_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;

   assign ctl.capture = accept;
   assign ctl.execute = (state_ff == ST_EXEC);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (ctl.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/fcfl_dp.sv
// datapath: free-list head registers, link memory, pool size and response word
// depends on fcfl_pkg and fcfl_ram
module fcfl_dp #(
   parameter int MAX_CHUNKS = fcfl_pkg::DEFAULT_MAX_CHUNKS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  fcfl_pkg::ctl_type              ctl,
   input  logic [fcfl_pkg::CMD_W-1:0]     req_command,
   input  logic [fcfl_pkg::INDEX_W-1:0]   req_chunk_index,
   input  logic                           csr_write_en,
   input  logic [fcfl_pkg::COUNT_W-1:0]   csr_pool_chunks,
   output logic [fcfl_pkg::STATUS_W-1:0]  rsp_status,
   output logic [fcfl_pkg::INDEX_W-1:0]   rsp_granted_index,
   output logic [fcfl_pkg::COUNT_W-1:0]   rsp_free_count
);
   import fcfl_pkg::*;

   localparam int IdxW      = $clog2(MAX_CHUNKS);
   localparam int CntW      = $clog2(MAX_CHUNKS + 1);
   localparam int ResetPool = (MAX_CHUNKS < 1024) ? MAX_CHUNKS : 1024;
   localparam logic [CntW-1:0] NullLink = CntW'(MAX_CHUNKS);
   localparam logic [CntW-1:0] One      = CntW'(1);

   logic [CntW-1:0]      pool_ff, pool_in;
   logic [CntW-1:0]      head_index_ff, head_index_in;
   logic [CntW-1:0]      head_run_ff, head_run_in;
   logic [CntW-1:0]      head_next_ff, head_next_in;
   logic [CntW-1:0]      free_total_ff, free_total_in;
   logic [CntW-1:0]      tail_start_ff, tail_start_in;
   command_type          cmd_ff;
   logic [INDEX_W-1:0]   idx_ff;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [INDEX_W-1:0]   granted_ff, granted_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   logic [CntW-1:0]      link_rdata;
   logic                 link_wr_en;
   logic [31:0]          cfg_wide;
   logic [CntW-1:0]      cfg_pool;
   logic                 alloc_empty;
   logic                 free_bad;
   logic [CntW-1:0]      tail_after;
   logic [CntW-1:0]      next_node;

   fcfl_ram #(
      .Width(CntW),
      .Depth(MAX_CHUNKS)
   ) u_link_ram (
      .clock  (clock),
      .wr_en  (link_wr_en),
      .wr_addr(head_index_ff[IdxW-1:0]),
      .wr_data(head_next_ff),
      .rd_en  (ctl.capture),
      .rd_addr(head_next_ff[IdxW-1:0]),
      .rd_data(link_rdata)
   );

   // clamp written pool size into one to max
   always_comb begin
      cfg_wide = 32'(csr_pool_chunks);
      priority if (cfg_wide == 32'd0) begin
         cfg_pool = One;
      end else if (cfg_wide > 32'(MAX_CHUNKS)) begin
         cfg_pool = NullLink;
      end else begin
         cfg_pool = CntW'(cfg_wide);
      end
   end

   assign alloc_empty = (free_total_ff == '0) || (head_index_ff >= NullLink)
                        || (head_run_ff == '0);
   assign free_bad    = (32'(idx_ff) >= 32'(pool_ff)) || (32'(idx_ff) >= 32'(MAX_CHUNKS))
                        || (free_total_ff >= pool_ff);
   assign tail_after  = (head_index_ff == tail_start_ff) ? head_index_ff + One
                                                         : tail_start_ff;
   assign next_node   = head_next_ff;
   assign link_wr_en  = ctl.execute && (cmd_ff == CMD_FREE) && !free_bad
                        && (head_index_ff < NullLink);

   always_comb begin
      head_index_in = head_index_ff;
      head_run_in   = head_run_ff;
      head_next_in  = head_next_ff;
      free_total_in = free_total_ff;
      tail_start_in = tail_start_ff;
      granted_in    = '0;
      status_in     = STAT_EMPTY;
      unique case (cmd_ff)
         CMD_ALLOC: begin
            if (!alloc_empty) begin
               status_in     = STAT_ALLOC;
               granted_in    = INDEX_W'(head_index_ff);
               free_total_in = free_total_ff - One;
               tail_start_in = tail_after;
               if (head_run_ff > One) begin
                  head_index_in = head_index_ff + One;
                  head_run_in   = head_run_ff - One;
               end else begin
                  head_index_in = next_node;
                  if (next_node < NullLink) begin
                     head_next_in = link_rdata;
                     head_run_in  = ((next_node == tail_after) && (next_node < pool_ff))
                                    ? pool_ff - next_node : One;
                  end else begin
                     head_next_in = NullLink;
                     head_run_in  = '0;
                  end
               end
            end
         end
         CMD_FREE: begin
            if (free_bad) begin
               status_in = STAT_BAD;
            end else begin
               status_in     = STAT_FREED;
               head_next_in  = (head_index_ff < NullLink) ? head_index_ff : NullLink;
               head_index_in = CntW'(idx_ff);
               head_run_in   = One;
               free_total_in = free_total_ff + One;
            end
         end
         default: begin
            status_in = STAT_BAD;
         end
      endcase
      count_in = COUNT_W'(free_total_in);
   end

   assign pool_in = csr_write_en ? cfg_pool : pool_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff       <= CntW'(ResetPool);
         head_index_ff <= '0;
         head_run_ff   <= CntW'(ResetPool);
         head_next_ff  <= NullLink;
         free_total_ff <= CntW'(ResetPool);
         tail_start_ff <= '0;
      end else if (csr_write_en) begin
         pool_ff       <= pool_in;
         head_index_ff <= '0;
         head_run_ff   <= pool_in;
         head_next_ff  <= NullLink;
         free_total_ff <= pool_in;
         tail_start_ff <= '0;
      end else if (ctl.execute) begin
         head_index_ff <= head_index_in;
         head_run_ff   <= head_run_in;
         head_next_ff  <= head_next_in;
         free_total_ff <= free_total_in;
         tail_start_ff <= tail_start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff <= command_type'(req_command);
         idx_ff <= req_chunk_index;
      end
      if (ctl.execute) begin
         status_ff  <= status_in;
         granted_ff <= granted_in;
         count_ff   <= count_in;
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_granted_index = granted_ff;
   assign rsp_free_count    = count_ff;

endmodule

// File: rtl/fixed_chunk_free_list_allocator_core.sv
// fixed-size chunk pool allocator with a free list of runs
// request channel carries a command word (allocate, or free one chunk index);
// the response channel returns status, granted chunk index and free count.
// csr_write_en with csr_pool_chunks sets the pool size (clamped to 1..MAX_CHUNKS)
// and reinitializes the pool as one free run from chunk 0; write only when idle.
// each request passes through two steps: capture (link memory read at the head link)
// and execute (head update, link memory write on a free, response load).
// rsp_valid is registered and rises in the cycle after execute. no new request is
// accepted while a request is in execute, set by the single read-then-write pass
// on the link memory. the response sits in an output register, so a new request is
// accepted in the cycle that the previous response is taken.
// while rsp_stall holds a pending response, req_stall stays high.
// synchronous reset: pool of min(MAX_CHUNKS, 1024) chunks, all free; the link
// memory is not cleared, entries are written before they are followed.
// depends on fcfl_pkg, fcfl_ctrl, fcfl_dp, fcfl_ram
module fixed_chunk_free_list_allocator_core #(
   parameter int MAX_CHUNKS = fcfl_pkg::DEFAULT_MAX_CHUNKS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [fcfl_pkg::CMD_W-1:0]     req_command,
   input  logic [fcfl_pkg::INDEX_W-1:0]   req_chunk_index,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [fcfl_pkg::STATUS_W-1:0]  rsp_status,
   output logic [fcfl_pkg::INDEX_W-1:0]   rsp_granted_index,
   output logic [fcfl_pkg::COUNT_W-1:0]   rsp_free_count,
   input  logic                           csr_write_en,
   input  logic [fcfl_pkg::COUNT_W-1:0]   csr_pool_chunks
);
   import fcfl_pkg::*;

   ctl_type ctl;

   fcfl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .ctl      (ctl)
   );

   fcfl_dp #(
      .MAX_CHUNKS(MAX_CHUNKS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .req_command      (req_command),
      .req_chunk_index  (req_chunk_index),
      .csr_write_en     (csr_write_en),
      .csr_pool_chunks  (csr_pool_chunks),
      .rsp_status       (rsp_status),
      .rsp_granted_index(rsp_granted_index),
      .rsp_free_count   (rsp_free_count)
   );

   a_capture_then_exec: assert property (@(posedge clock) disable iff (reset)
      ctl.capture |=> ctl.execute && !ctl.capture)
      else $error("capture not followed by execute");

   a_exec_output_free: assert property (@(posedge clock) disable iff (reset)
      ctl.execute |-> !rsp_valid)
      else $error("response loaded over a pending word");

   a_exec_raises_valid: assert property (@(posedge clock) disable iff (reset)
      ctl.execute |=> rsp_valid)
      else $error("execute did not raise rsp_valid");

   a_granted_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_ALLOC) |-> (rsp_granted_index == '0))
      else $error("granted index nonzero without allocation");

endmodule
